### rtl/core/seven_segment_mux_display_core_macros.svh
// ----------------------------------------------------------------------------
// seven segment display core assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_MUX_DISPLAY_CORE_MACROS_SVH
`define SEVEN_SEGMENT_MUX_DISPLAY_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SSMD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ssmd assertion failed");
// next-cycle implication
`define SSMD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ssmd assertion failed");
`else
`define SSMD_ASSERT_IMP(label, ante, cons)
`define SSMD_ASSERT_NXT(label, ante, cons)
`endif

`endif

### rtl/core/ssmd_pkg.sv
// ----------------------------------------------------------------------------
// ssmd_pkg
// types, constants and the glyph table of the seven segment display core
// ----------------------------------------------------------------------------
package ssmd_pkg;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam int DIGITS = 4;
	localparam int POS_W = 2;

	localparam logic [7:0] SEG_BLANK = 8'hFF;
	localparam logic [13:0] MAX_SHOWN = 14'd9999;

	// classified request as it waits in the queue
	typedef struct packed {
		logic mode;
		logic [13:0] value;
		logic [3:0] q1000;
		logic [6:0] q100;
		logic [9:0] q10;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	function automatic logic [7:0] glyph(input logic [3:0] d);
		logic [7:0] p;
		case (d)
			4'd0: p = 8'hC0;
			4'd1: p = 8'hF9;
			4'd2: p = 8'hA4;
			4'd3: p = 8'hB0;
			4'd4: p = 8'h99;
			4'd5: p = 8'h92;
			4'd6: p = 8'h82;
			4'd7: p = 8'hF8;
			4'd8: p = 8'h80;
			4'd9: p = 8'h90;
			default: p = SEG_BLANK;
		endcase
		return p;
	endfunction

endpackage

### rtl/core/ssmd_front.sv
// ----------------------------------------------------------------------------
// ssmd_front
// saturates the number and forms its decimal quotients by reciprocal multiply
// ----------------------------------------------------------------------------
module ssmd_front (
	input  logic             mode,
	input  logic [15:0]      number,
	output ssmd_pkg::cmd_t   cmd
);
	import ssmd_pkg::*;

	logic [13:0] sat;
	logic [27:0] p1000;
	logic [27:0] p100;
	logic [27:0] p10;

	// saturate to the largest value four digits can show
	assign sat = (number > {2'b00, MAX_SHOWN}) ? MAX_SHOWN : number[13:0];

	// exact floor quotients for values up to 9999
	assign p1000 = 28'(sat) * 28'd8389;
	assign p100 = 28'(sat) * 28'd5243;
	assign p10 = 28'(sat) * 28'd6554;

	always_comb begin
		cmd.mode = mode;
		cmd.value = sat;
		cmd.q1000 = p1000[26:23];
		cmd.q100 = p100[25:19];
		cmd.q10 = p10[25:16];
	end

endmodule

### rtl/core/ssmd_queue.sv
// ----------------------------------------------------------------------------
// ssmd_queue
// short fifo of classified requests between the front and back parts
// ----------------------------------------------------------------------------
module ssmd_queue #(
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ssmd_pkg::cmd_t       push_cmd,
	input  logic                 pop,
	output ssmd_pkg::cmd_t       head,
	output ssmd_pkg::q_status_t  status
);
	import ssmd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	assign head = mem_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full = (count_q == CW'(DEPTH));

endmodule

### rtl/core/ssmd_back.sv
// ----------------------------------------------------------------------------
// ssmd_back
// executes queued requests: stores digit patterns or emits a scan result
// ----------------------------------------------------------------------------
module ssmd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ssmd_pkg::cmd_t       head,
	input  ssmd_pkg::q_status_t  status,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           segments,
	output logic [3:0]           digit_enable
);
	import ssmd_pkg::*;

	logic [7:0] pat_q [DIGITS];
	logic [POS_W-1:0] pos_q;
	logic out_valid_q;
	logic [7:0] seg_q;
	logic [3:0] en_q;

	logic [6:0] hund_w;
	logic [9:0] tens_w;
	logic [13:0] unit_w;
	logic [7:0] new_pat [DIGITS];

	// remainders from neighboring quotients, times ten as shift and add
	assign hund_w = head.q100 - ({head.q1000, 3'b000} + {2'b00, head.q1000, 1'b0});
	assign tens_w = head.q10 - ({head.q100, 3'b000} + {2'b00, head.q100, 1'b0});
	assign unit_w = head.value - ({1'b0, head.q10, 3'b000} + {3'b000, head.q10, 1'b0});

	// leading zeros blank, units always shown
	always_comb begin
		new_pat[0] = (head.q1000 == '0) ? SEG_BLANK : glyph(head.q1000);
		new_pat[1] = (head.q100 == '0) ? SEG_BLANK : glyph(hund_w[3:0]);
		new_pat[2] = (head.q10 == '0) ? SEG_BLANK : glyph(tens_w[3:0]);
		new_pat[3] = glyph(unit_w[3:0]);
	end

	// loads always drain, ticks need a free output register
	assign pop = !status.empty && ((head.mode == MODE_LOAD) || !out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++) begin
				pat_q[i] <= '0;
			end
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && (head.mode == MODE_LOAD)) begin
				for (int i = 0; i < DIGITS; i++) begin
					pat_q[i] <= new_pat[i];
				end
			end
			if (pop && (head.mode == MODE_TICK)) begin
				pos_q <= pos_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (head.mode == MODE_TICK)) begin
			seg_q <= pat_q[pos_q];
			en_q <= ~(4'b0001 << pos_q);
		end
	end

	assign out_valid = out_valid_q;
	assign segments = seg_q;
	assign digit_enable = en_q;

endmodule

### rtl/core/seven_segment_mux_display_core.sv
// ----------------------------------------------------------------------------
// seven_segment_mux_display_core
// four-digit multiplexed seven segment display driver
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready): each request carries mode and number.
//   mode load stores the number, saturated to 9999, as four active-low
//   digit patterns with leading zeros blanked; it gives no result.
//   mode tick gives one result and moves the scan position on, modulo four.
// output channel (out_valid/out_ready): segments is the stored pattern of the
//   current position, digit_enable drives only that position's line low.
// a tick is written into the queue, then into the result register by the back.
// throughput: one request per cycle unless stalled; the front classifies and
//   multiplies, a two-entry queue passes requests to the back, one per cycle.
// a receiver stall holds the result register; loads keep draining past it,
//   and ticks back up into the queue until in_ready drops.
// reset: patterns clear to zero (every segment lit), position to digit 0,
//   queue and output register empty.
// ----------------------------------------------------------------------------
`include "seven_segment_mux_display_core_macros.svh"

module seven_segment_mux_display_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [15:0] number,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  segments,
	output logic [3:0]  digit_enable
);
	import ssmd_pkg::*;

	cmd_t front_cmd;
	cmd_t head_cmd;
	q_status_t q_status;
	logic push;
	logic pop;

	// front: saturation and decimal quotients
	ssmd_front u_front (
		.mode   (mode),
		.number (number),
		.cmd    (front_cmd)
	);

	// accept whenever the queue has room
	assign in_ready = !q_status.full;
	assign push = in_valid && in_ready;

	ssmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.pop      (pop),
		.head     (head_cmd),
		.status   (q_status)
	);

	// back: pattern store, scan position and result register
	ssmd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head_cmd),
		.status       (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.segments     (segments),
		.digit_enable (digit_enable)
	);

	// an accepted request is queued by the next cycle unless it was drained
	`SSMD_ASSERT_NXT(a_push_lands, push && !pop, !q_status.empty)
	// the back never drains an empty queue
	`SSMD_ASSERT_IMP(a_pop_nonempty, pop, !q_status.empty)
	// a shown result selects exactly one digit line
	`SSMD_ASSERT_IMP(a_one_digit, out_valid, $countones(digit_enable) == 3)

endmodule
